// ===== rtl/core/pfc_pkg.sv =====
// Shared types, format codes and lookup functions for the pixel format converter.
package pfc_pkg;

   // Framebuffer and source format codes.
   localparam logic [4:0] FMT_UNKNOWN   = 5'd0;
   localparam logic [4:0] FMT_RGB32     = 5'd1;
   localparam logic [4:0] FMT_RGBA32    = 5'd2;
   localparam logic [4:0] FMT_BGR32     = 5'd3;
   localparam logic [4:0] FMT_BGRA32    = 5'd4;
   localparam logic [4:0] FMT_RGB565    = 5'd5;
   localparam logic [4:0] FMT_RGB555    = 5'd6;
   localparam logic [4:0] FMT_BGR565    = 5'd7;
   localparam logic [4:0] FMT_BGR555    = 5'd8;
   localparam logic [4:0] FMT_RGB24     = 5'd9;
   localparam logic [4:0] FMT_BGR24     = 5'd10;
   localparam logic [4:0] FMT_ARGB8888  = 5'd11;
   localparam logic [4:0] FMT_ARGB4444  = 5'd12;
   localparam logic [4:0] FMT_RGBA4444  = 5'd13;
   localparam logic [4:0] FMT_ABGR4444  = 5'd14;
   localparam logic [4:0] FMT_BGRA4444  = 5'd15;
   localparam logic [4:0] FMT_RGB332    = 5'd16;

   // Channel slots inside the per-channel operand vector.
   localparam int CH_A = 0;
   localparam int CH_R = 1;
   localparam int CH_G = 2;
   localparam int CH_B = 3;
   localparam int NUM_CH = 4;

   // Number of register stages from an accepted beat to the result strobe.
   localparam int PIPE_DEPTH = 5;

   // Format classes: formats of one class share their channel scales.
   typedef enum logic [2:0] {
      CLS_NONE = 3'd0,
      CLS_8    = 3'd1,
      CLS_565  = 3'd2,
      CLS_555  = 3'd3,
      CLS_4444 = 3'd4,
      CLS_332  = 3'd5
   } pcls_type;

   // Input beat.
   typedef struct packed {
      logic [4:0] source_format;
      logic [7:0] alpha_in;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [31:0] pixel_word;
      logic [2:0]  byte_count;
   } rsp_type;

   // Reciprocal for a constant divisor: q = (x * mult) >> shift, exact for 16-bit x.
   typedef struct packed {
      logic [16:0] mult;
      logic [4:0]  shift;
   } recip_type;

   // Operands of one channel's rescale.
   typedef struct packed {
      logic [7:0]  value;
      logic [7:0]  nmax;
      logic [16:0] mult;
      logic [4:0]  shift;
   } scl_op_type;

   // Class of a format code; codes beyond the list have no class.
   function automatic pcls_type fmt_class(input logic [4:0] fmt);
      pcls_type cls;
      unique case (fmt)
         FMT_RGB32, FMT_RGBA32, FMT_BGR32, FMT_BGRA32,
         FMT_RGB24, FMT_BGR24, FMT_ARGB8888:                   cls = CLS_8;
         FMT_RGB565, FMT_BGR565:                               cls = CLS_565;
         FMT_RGB555, FMT_BGR555:                               cls = CLS_555;
         FMT_ARGB4444, FMT_RGBA4444, FMT_ABGR4444, FMT_BGRA4444: cls = CLS_4444;
         FMT_RGB332:                                           cls = CLS_332;
         default:                                              cls = CLS_NONE;
      endcase
      return cls;
   endfunction

   // Largest value of a channel in a class.
   function automatic logic [7:0] chan_max(input pcls_type cls, input int ch);
      logic [7:0] mx;
      unique case (cls)
         CLS_8:    mx = 8'd255;
         CLS_565:  mx = (ch == CH_A) ? 8'd255 : ((ch == CH_G) ? 8'd63 : 8'd31);
         CLS_555:  mx = (ch == CH_A) ? 8'd255 : 8'd31;
         CLS_4444: mx = 8'd15;
         CLS_332:  mx = (ch == CH_A) ? 8'd255 : ((ch == CH_B) ? 8'd3 : 8'd7);
         default:  mx = 8'd1;
      endcase
      return mx;
   endfunction

   // Reciprocal constants: mult = ceil(2^(16+l) / d) with l = ceil(log2 d).
   function automatic recip_type recip_of(input logic [7:0] divisor);
      recip_type rc;
      unique case (divisor)
         8'd255:  rc = '{mult: 17'd65794, shift: 5'd24};
         8'd63:   rc = '{mult: 17'd66577, shift: 5'd22};
         8'd31:   rc = '{mult: 17'd67651, shift: 5'd21};
         8'd15:   rc = '{mult: 17'd69906, shift: 5'd20};
         8'd7:    rc = '{mult: 17'd74899, shift: 5'd19};
         8'd3:    rc = '{mult: 17'd87382, shift: 5'd18};
         default: rc = '{mult: 17'd65536, shift: 5'd16};
      endcase
      return rc;
   endfunction

endpackage

// ===== rtl/core/pixel_format_convert_pack.sv =====
// Top level of the pixel format converter and packer.
//
// Usage: write the framebuffer format code on the csr_ channel (csr_valid with
// csr_data; csr_ready is always high) while no pixel is in flight. Then drive
// one color beat per cycle on req_data with start high. busy stays low, so a
// beat is taken every cycle that start is high.
// Each beat yields exactly one result beat: rsp_valid pulses for one cycle
// with rsp_data holding the packed little-endian pixel word and its byte count.
// Each beat passes through one decode stage, three rescale stages (multiply by
// the new channel maximum, multiply by the reciprocal of the old one, shift), and
// one packing stage. Throughput is one pixel per clock, fixed by the fully
// pipelined rescale multipliers.
// Reset clears the format register to unknown and drops every beat in flight;
// it needs no clearing pass.
// The receiver cannot stall: results are presented once and must be taken.
module pixel_format_convert_pack
   import pfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);

   logic [4:0]              target_ff;
   logic [4:0]              target_in;
   logic [PIPE_DEPTH-1:0]   valid_ff;
   logic [PIPE_DEPTH-1:0]   valid_in;
   logic                    accept;
   scl_op_type [NUM_CH-1:0] ops;
   logic [4:0]              tgt_s1;
   logic [4:0]              tgt_s2_ff;
   logic [4:0]              tgt_s3_ff;
   logic [4:0]              tgt_s4_ff;
   logic [7:0]              chan [NUM_CH];

   // The pipeline never holds off a beat.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Format register.
   assign target_in = (csr_valid && csr_ready) ? csr_data : target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= FMT_UNKNOWN;
      end else begin
         target_ff <= target_in;
      end
   end

   // Valid bits travel alongside the payload stages.
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   pfc_decode u_decode (
      .clock     (clock),
      .req_data  (req_data),
      .target    (target_ff),
      .ops_ff    (ops),
      .target_ff (tgt_s1)
   );

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
      pfc_scale u_scale (
         .clock    (clock),
         .op       (ops[ch]),
         .value_ff (chan[ch])
      );
   end

   // Target code follows its pixel through the rescale stages.
   always_ff @(posedge clock) begin
      tgt_s2_ff <= tgt_s1;
      tgt_s3_ff <= tgt_s2_ff;
      tgt_s4_ff <= tgt_s3_ff;
   end

   pfc_pack u_pack (
      .clock  (clock),
      .target (tgt_s4_ff),
      .alpha  (chan[CH_A]),
      .red    (chan[CH_R]),
      .green  (chan[CH_G]),
      .blue   (chan[CH_B]),
      .rsp_ff (rsp_data)
   );

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

`ifndef SYNTHESIS
   a_beat_in_gives_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("accepted beat produced no result");

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result without a matching accepted beat");

   a_empty_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.byte_count == 3'd0)) |-> (rsp_data.pixel_word == 32'd0))
      else $error("bytes written for an unknown target");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_count <= 3'd4))
      else $error("byte count out of range");
`endif

endmodule

// ===== rtl/core/pfc_decode.sv =====
// First stage: format classes and per-channel scale and reciprocal selection.
module pfc_decode
   import pfc_pkg::*;
(
   input  logic                        clock,
   input  req_type                     req_data,
   input  logic [4:0]                  target,
   output scl_op_type [NUM_CH-1:0]     ops_ff,
   output logic [4:0]                  target_ff
);

   pcls_type                    tcls;
   pcls_type                    scls;
   logic                        scale_rgb;
   logic                        scale_a;
   scl_op_type [NUM_CH-1:0]     ops_in;
   logic [7:0]                  values [NUM_CH];

   assign tcls = fmt_class(target);
   assign scls = fmt_class(req_data.source_format);

   // Color channels rescale between two known, different classes.
   assign scale_rgb = (req_data.source_format != target) && (tcls != CLS_NONE) &&
                      (scls != CLS_NONE) && (scls != tcls);

   // Alpha rescales only between the 8-bit class and the 4444 class.
   assign scale_a = scale_rgb &&
                    (((tcls == CLS_8) && (scls == CLS_4444)) ||
                     ((tcls == CLS_4444) && (scls == CLS_8)));

   assign values[CH_A] = req_data.alpha_in;
   assign values[CH_R] = req_data.red_in;
   assign values[CH_G] = req_data.green_in;
   assign values[CH_B] = req_data.blue_in;

   // A channel that keeps its value scales by one over one.
   always_comb begin
      recip_type rc;
      logic      en;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         en = (ch == CH_A) ? scale_a : scale_rgb;
         rc = recip_of(en ? chan_max(scls, ch) : 8'd1);
         ops_in[ch].value = values[ch];
         ops_in[ch].nmax  = en ? chan_max(tcls, ch) : 8'd1;
         ops_in[ch].mult  = rc.mult;
         ops_in[ch].shift = rc.shift;
      end
   end

   // Payload register; validity travels in the top level.
   always_ff @(posedge clock) begin
      ops_ff    <= ops_in;
      target_ff <= target;
   end

endmodule

// ===== rtl/core/pfc_scale.sv =====
// Three-stage channel rescale: multiply by new maximum, by reciprocal, then shift.
module pfc_scale
   import pfc_pkg::*;
(
   input  logic       clock,
   input  scl_op_type op,
   output logic [7:0] value_ff
);

   logic [15:0] prod_ff;
   logic [15:0] prod_in;
   logic [16:0] mult_ff;
   logic [4:0]  shift_ff;
   logic [4:0]  shift2_ff;
   logic [32:0] quot_ff;
   logic [32:0] quot_in;
   logic [32:0] shifted;
   logic [7:0]  value_in;

   // Stage one: channel times the new maximum.
   assign prod_in = 16'(op.value) * 16'(op.nmax);

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mult_ff  <= op.mult;
      shift_ff <= op.shift;
   end

   // Stage two: multiply by the reciprocal of the old maximum.
   assign quot_in = 33'(prod_ff) * 33'(mult_ff);

   always_ff @(posedge clock) begin
      quot_ff   <= quot_in;
      shift2_ff <= shift_ff;
   end

   // Stage three: drop the fraction and wrap to eight bits.
   assign shifted  = quot_ff >> shift2_ff;
   assign value_in = shifted[7:0];

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/core/pfc_pack.sv =====
// Final stage: packs the rescaled channels into the target byte layout.
module pfc_pack
   import pfc_pkg::*;
(
   input  logic       clock,
   input  logic [4:0] target,
   input  logic [7:0] alpha,
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   output rsp_type    rsp_ff
);

   rsp_type rsp_in;

   // Byte layout per target format; unknown targets write nothing.
   always_comb begin
      rsp_in = '0;
      unique case (target)
         FMT_RGB32: begin
            rsp_in.pixel_word = {8'd0, blue, green, red};
            rsp_in.byte_count = 3'd4;
         end
         FMT_RGBA32: begin
            rsp_in.pixel_word = {alpha, blue, green, red};
            rsp_in.byte_count = 3'd4;
         end
         FMT_BGR32: begin
            rsp_in.pixel_word = {8'd0, red, green, blue};
            rsp_in.byte_count = 3'd4;
         end
         FMT_BGRA32, FMT_ARGB8888: begin
            rsp_in.pixel_word = {alpha, red, green, blue};
            rsp_in.byte_count = 3'd4;
         end
         FMT_RGB24: begin
            rsp_in.pixel_word = {8'd0, blue, green, red};
            rsp_in.byte_count = 3'd3;
         end
         FMT_BGR24: begin
            rsp_in.pixel_word = {8'd0, red, green, blue};
            rsp_in.byte_count = 3'd3;
         end
         FMT_RGB565: begin
            rsp_in.pixel_word = {16'd0, red[4:0], green[5:0], blue[4:0]};
            rsp_in.byte_count = 3'd2;
         end
         FMT_RGB555: begin
            rsp_in.pixel_word = {17'd0, red[4:0], green[4:0], blue[4:0]};
            rsp_in.byte_count = 3'd2;
         end
         FMT_BGR565: begin
            rsp_in.pixel_word = {16'd0, blue[4:0], green[5:0], red[4:0]};
            rsp_in.byte_count = 3'd2;
         end
         FMT_BGR555: begin
            rsp_in.pixel_word = {17'd0, blue[4:0], green[4:0], red[4:0]};
            rsp_in.byte_count = 3'd2;
         end
         FMT_ARGB4444: begin
            rsp_in.pixel_word = {16'd0, alpha[3:0], red[3:0], green[3:0], blue[3:0]};
            rsp_in.byte_count = 3'd2;
         end
         FMT_RGBA4444: begin
            rsp_in.pixel_word = {16'd0, red[3:0], green[3:0], blue[3:0], alpha[3:0]};
            rsp_in.byte_count = 3'd2;
         end
         FMT_ABGR4444: begin
            rsp_in.pixel_word = {16'd0, alpha[3:0], blue[3:0], green[3:0], red[3:0]};
            rsp_in.byte_count = 3'd2;
         end
         FMT_BGRA4444: begin
            rsp_in.pixel_word = {16'd0, blue[3:0], green[3:0], red[3:0], alpha[3:0]};
            rsp_in.byte_count = 3'd2;
         end
         FMT_RGB332: begin
            rsp_in.pixel_word = {24'd0, red[2:0], green[2:0], blue[1:0]};
            rsp_in.byte_count = 3'd1;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
